/* src/lzwse_pkg.sv */
// ----------------------------------------------------------------------------
// lzwse_pkg
// Shared types and constants of the LZW stream encoder.
// ----------------------------------------------------------------------------
package lzwse_pkg;

    // code space
    localparam int CODE_BITS  = 12;
    localparam int BYTE_BITS  = 8;
    localparam int FIRST_CODE = 256;
    localparam int CODE_LIMIT = 1 << CODE_BITS;

    // hash table holds twice as many slots as there are codes
    localparam int HASH_BITS  = CODE_BITS + 1;

    // default queue address widths and epoch tag width
    localparam int ITEM_Q_AW  = 2;
    localparam int RES_Q_AW   = 2;
    localparam int EPOCH_BITS = 8;

    // input transaction
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 end_of_message;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 final_code;
    } t_out;

    // classified item between front and back
    typedef struct packed {
        t_in  tx;
        logic first_byte;
    } t_item;

endpackage

/* src/lzwse_fifo.sv */
// ----------------------------------------------------------------------------
// lzwse_fifo
// Small register queue with valid/ready on both sides and a near-full flag.
// ----------------------------------------------------------------------------
module lzwse_fifo #(
    parameter int WIDTH = 8,
    parameter int AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_almost_full
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             push;
    logic             pop;

    // handshake and status
    assign o_push_ready  = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid   = (r_count != '0);
    assign o_pop_data    = r_mem[r_rd_ptr];
    assign o_almost_full = (r_count >= (AW+1)'(DEPTH - 1));
    assign push          = i_push_valid && o_push_ready;
    assign pop           = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* src/lzwse_front.sv */
// ----------------------------------------------------------------------------
// lzwse_front
// Input stage: registers each byte and marks the first byte of a message.
// ----------------------------------------------------------------------------
module lzwse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lzwse_pkg::t_in    i_data,
    output logic              o_item_valid,
    input  logic              i_item_ready,
    output lzwse_pkg::t_item  o_item
);

    logic             r_valid;
    logic             r_first;
    lzwse_pkg::t_item r_item;
    logic             accept;

    assign o_ready      = !r_valid || i_item_ready;
    assign accept       = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // stage valid and message boundary tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_first <= 1'b1;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_first <= i_data.end_of_message;
            end else if (i_item_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // classified payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.tx         <= i_data;
            r_item.first_byte <= r_first;
        end
    end

endmodule

/* src/lzwse_back.sv */
// ----------------------------------------------------------------------------
// lzwse_back
// Match engine: hash table lookup with linear probing, code emission,
// learning of new strings and epoch based dictionary clearing.
// ----------------------------------------------------------------------------
module lzwse_back #(
    parameter int EPOCH_BITS = lzwse_pkg::EPOCH_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  lzwse_pkg::t_item  i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  logic              i_res_afull,
    output lzwse_pkg::t_out   o_res
);

    localparam int CB    = lzwse_pkg::CODE_BITS;
    localparam int BB    = lzwse_pkg::BYTE_BITS;
    localparam int HB    = lzwse_pkg::HASH_BITS;
    localparam int DEPTH = 1 << HB;
    localparam int EW    = EPOCH_BITS + CB + BB + CB;

    // entry slices: epoch tag, key (prefix, byte), code
    localparam int TAG_LSB = CB + BB + CB;
    localparam int KEY_LSB = CB;

    localparam logic [CB:0] FIRST_CODE = (CB+1)'(lzwse_pkg::FIRST_CODE);
    localparam logic [CB:0] CODE_LIMIT = (CB+1)'(lzwse_pkg::CODE_LIMIT);
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

    // engine states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    logic [EW-1:0]         r_mem [DEPTH];
    logic [EW-1:0]         r_rd_data;

    logic [1:0]            r_state,     n_state;
    logic [CB-1:0]         r_cur,       n_cur;
    logic [CB:0]           r_next_free, n_next_free;
    logic [EPOCH_BITS-1:0] r_epoch,     n_epoch;
    logic [HB-1:0]         r_clr_addr,  n_clr_addr;
    logic [HB-1:0]         r_probe,     n_probe;
    logic [BB-1:0]         r_byte,      n_byte;
    logic                  r_eom,       n_eom;

    logic                  mem_we;
    logic [HB-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic                  mem_re;
    logic [HB-1:0]         mem_raddr;

    logic [EPOCH_BITS-1:0] rd_tag;
    logic [CB+BB-1:0]      rd_key;
    logic [CB-1:0]         rd_code;
    logic                  slot_live;
    logic                  slot_hit;

    // hash of (prefix, byte) into a table slot
    function automatic logic [HB-1:0] f_hash(input logic [CB-1:0] prefix,
                                             input logic [BB-1:0] nbyte);
        f_hash = HB'(prefix) ^ (HB'(nbyte) << (HB - BB));
    endfunction

    // slot compare
    assign rd_tag    = r_rd_data[TAG_LSB +: EPOCH_BITS];
    assign rd_key    = r_rd_data[KEY_LSB +: CB+BB];
    assign rd_code   = r_rd_data[CB-1:0];
    assign slot_live = (rd_tag == r_epoch);
    assign slot_hit  = slot_live && (rd_key == {r_cur, r_byte});

    // engine next state
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_next_free = r_next_free;
        n_epoch     = r_epoch;
        n_clr_addr  = r_clr_addr;
        n_probe     = r_probe;
        n_byte      = r_byte;
        n_eom       = r_eom;
        o_item_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_probe;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_probe;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid && !i_res_afull) begin
                    o_item_ready = 1'b1;
                    n_byte       = i_item.tx.data_byte;
                    n_eom        = i_item.tx.end_of_message;
                    if (i_item.first_byte) begin
                        n_cur   = CB'(i_item.tx.data_byte);
                        n_state = i_item.tx.end_of_message ? ST_FIN : ST_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = f_hash(r_cur, i_item.tx.data_byte);
                        n_probe   = mem_raddr;
                        n_state   = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                priority if (slot_hit) begin
                    n_cur   = rd_code;
                    n_state = r_eom ? ST_FIN : ST_IDLE;
                end else if (!slot_live) begin
                    // miss: emit current code, learn pair if room left
                    o_res_valid     = 1'b1;
                    o_res.code      = r_cur;
                    o_res.final_code = 1'b0;
                    if (r_next_free < CODE_LIMIT) begin
                        mem_we      = 1'b1;
                        mem_wdata   = {r_epoch, r_cur, r_byte, r_next_free[CB-1:0]};
                        n_next_free = r_next_free + 1'b1;
                    end
                    n_cur   = CB'(r_byte);
                    n_state = r_eom ? ST_FIN : ST_IDLE;
                end else begin
                    // collision: probe next slot
                    mem_re    = 1'b1;
                    mem_raddr = r_probe + 1'b1;
                    n_probe   = mem_raddr;
                end
            end
            ST_FIN: begin
                o_res_valid      = 1'b1;
                o_res.code       = r_cur;
                o_res.final_code = 1'b1;
                n_next_free      = FIRST_CODE;
                n_cur            = '0;
                if (r_epoch == '1) begin
                    n_clr_addr = '0;
                    n_state    = ST_CLR;
                end else begin
                    n_epoch = r_epoch + 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CLR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_epoch = EPOCH_FIRST;
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cur       <= '0;
            r_next_free <= FIRST_CODE;
            r_epoch     <= EPOCH_FIRST;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_next_free <= n_next_free;
            r_epoch     <= n_epoch;
            r_clr_addr  <= n_clr_addr;
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_byte  <= n_byte;
        r_eom   <= n_eom;
    end

    // hash table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // result queue always has room when a code is emitted
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_res_ready)
        else $error("code emitted into a full result queue");

    // learned codes stay inside the code space
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= FIRST_CODE) && (r_next_free <= CODE_LIMIT))
        else $error("next free code out of range");

    // learning only overwrites a slot that is free in the live epoch
    a_learn_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == ST_CMP)) |-> !slot_live)
        else $error("learned entry overwrote a live slot");

    // end of message restores the empty dictionary
    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> ((r_next_free == FIRST_CODE) && (r_cur == '0)))
        else $error("dictionary not reset after final code");

    // epoch zero marks cleared slots and is never live
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("live epoch is zero");

endmodule

/* src/lzw_stream_encoder.sv */
// ----------------------------------------------------------------------------
// lzw_stream_encoder
// LZW encoder: bytes in, dictionary codes out, one message at a time.
// ----------------------------------------------------------------------------
// In the match engine each byte gets a hash table read, then a compare and
// decide step, with a further read for every extra probe after a hash
// collision; the first byte of a message skips the table, and the final
// code is sent from a state of its own. A new byte is taken only from idle.
// The dictionary is a 2^(CODE_BITS+1) slot hash table with linear probing
// whose single port sets the rate; entries are tagged with a message epoch
// so ending a message clears it at once. After reset, and after every
// 2^EPOCH_BITS-1 messages, a clearing pass sweeps every slot while no byte
// is taken. A queue on each side lets input and output stall independently;
// once the code space is full the dictionary freezes until the message ends.
// ----------------------------------------------------------------------------
module lzw_stream_encoder #(
    parameter int ITEM_Q_AW  = lzwse_pkg::ITEM_Q_AW,
    parameter int RES_Q_AW   = lzwse_pkg::RES_Q_AW,
    parameter int EPOCH_BITS = lzwse_pkg::EPOCH_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lzwse_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output lzwse_pkg::t_out  o_data
);

    lzwse_pkg::t_item front_item;
    logic             front_valid;
    logic             front_ready;
    lzwse_pkg::t_item q_item;
    logic             q_valid;
    logic             q_ready;
    lzwse_pkg::t_out  res;
    logic             res_valid;
    logic             res_ready;
    logic             res_afull;

    // input stage and classifier
    lzwse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    // item queue between front and engine
    lzwse_fifo #(
        .WIDTH ($bits(lzwse_pkg::t_item)),
        .AW    (ITEM_Q_AW)
    ) u_item_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push_valid  (front_valid),
        .o_push_ready  (front_ready),
        .i_push_data   (front_item),
        .o_pop_valid   (q_valid),
        .i_pop_ready   (q_ready),
        .o_pop_data    (q_item),
        .o_almost_full ()
    );

    // match engine
    lzwse_back #(
        .EPOCH_BITS (EPOCH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_afull  (res_afull),
        .o_res        (res)
    );

    // result queue toward the output
    lzwse_fifo #(
        .WIDTH ($bits(lzwse_pkg::t_out)),
        .AW    (RES_Q_AW)
    ) u_res_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push_valid  (res_valid),
        .o_push_ready  (res_ready),
        .i_push_data   (res),
        .o_pop_valid   (o_valid),
        .i_pop_ready   (i_ready),
        .o_pop_data    (o_data),
        .o_almost_full (res_afull)
    );

endmodule

/* sim/lzw_stream_encoder_tb.sv */
// ----------------------------------------------------------------------------
// lzw_stream_encoder_tb
// Self-checking bench for the LZW stream encoder: a directed table of short
// messages, then random messages of mixed content (random bytes, small
// alphabets, runs, repeated patterns), a burst of tiny messages, and one longer
// message of pattern and random bytes. Every accepted result is compared against
// typed directed-table codes or an exact-key dictionary predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lzw_stream_encoder_tb;

    localparam int CODE_W       = lzwse_pkg::CODE_BITS;
    localparam int KEY_BITS     = lzwse_pkg::CODE_BITS + lzwse_pkg::BYTE_BITS;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 64;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_MSG_LEN = 200;
    localparam int LONG_RAND_LO = 16;
    localparam int LONG_RAND_HI = 184;

    typedef enum int {MSG_RANDOM, MSG_ALPHABET, MSG_RUN, MSG_PATTERN} t_msg_kind;

    // one row of the directed table
    typedef struct packed {
        lzwse_pkg::t_in  tx;
        logic            typed;
        logic [1:0]      n;
        lzwse_pkg::t_out r0;
        lzwse_pkg::t_out r1;
    } t_dir_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    lzwse_pkg::t_in  i_data;
    logic            o_valid;
    logic            i_ready;
    lzwse_pkg::t_out o_data;

    // predictor state
    logic [CODE_W-1:0] dict_map [bit [KEY_BITS-1:0]];
    int unsigned       free_code;
    logic [CODE_W-1:0] cur_code;
    bit                in_string;
    lzwse_pkg::t_out   pred_res [2];
    int                pred_n;

    // expected codes in order of emission
    lzwse_pkg::t_out code_q [$];
    t_dir_row        dir_rows [$];

    int mismatch_count = 0;
    int rand_items     = 0;
    bit idle_on        = 1'b1;
    bit hold_req       = 1'b0;

    lzw_stream_encoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // exact-key LZW encoder, one byte per call
    task automatic lzw_predict(input lzwse_pkg::t_in tx);
        bit [KEY_BITS-1:0] key;
        pred_n = 0;
        if (!in_string) begin
            cur_code  = CODE_W'(tx.data_byte);
            in_string = 1'b1;
        end else begin
            key = {cur_code, tx.data_byte};
            if (dict_map.exists(key)) begin
                cur_code = dict_map[key];
            end else begin
                pred_res[pred_n] = {cur_code, 1'b0};
                pred_n++;
                // dictionary freezes once the code space is used up
                if (free_code < lzwse_pkg::CODE_LIMIT) begin
                    dict_map[key] = free_code[CODE_W-1:0];
                    free_code++;
                end
                cur_code = CODE_W'(tx.data_byte);
            end
        end
        if (tx.end_of_message) begin
            pred_res[pred_n] = {cur_code, 1'b1};
            pred_n++;
            dict_map.delete();
            free_code = lzwse_pkg::FIRST_CODE;
            cur_code  = '0;
            in_string = 1'b0;
        end
    endtask

    // present one transaction, return at the edge that accepts it
    task automatic drive_item(input lzwse_pkg::t_in tx);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tx;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic offer_byte(input lzwse_pkg::t_in tx);
        int k;
        drive_item(tx);
        lzw_predict(tx);
        for (k = 0; k < pred_n; k++) code_q.push_back(pred_res[k]);
    endtask

    task automatic send_message(input t_msg_kind kind, input int len);
        logic [7:0]     base;
        logic [7:0]     sym [5];
        int             width;
        int             i;
        lzwse_pkg::t_in tx;
        base  = 8'($urandom);
        width = $urandom_range(2, 5);
        for (i = 0; i < 5; i++) sym[i] = 8'($urandom);
        for (i = 0; i < len; i++) begin
            case (kind)
                MSG_RANDOM:   tx.data_byte = 8'($urandom);
                MSG_ALPHABET: tx.data_byte = 8'(base + $urandom_range(0, width - 1));
                MSG_RUN:      tx.data_byte = base;
                default:      tx.data_byte = sym[i % width];
            endcase
            tx.end_of_message = (i == len - 1);
            offer_byte(tx);
            rand_items++;
        end
    endtask

    // mostly short and medium messages, a few longer ones
    task automatic random_message();
        int pick;
        int len;
        pick = $urandom_range(0, 9);
        if (pick < 4)      len = $urandom_range(1, 4);
        else if (pick < 8) len = $urandom_range(5, 40);
        else               len = $urandom_range(41, 120);
        send_message(t_msg_kind'($urandom_range(0, 3)), len);
    endtask

    // drop valid, wait for all expected codes, then let the pipe go quiet
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (code_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] b, input int eom, input int typed,
                           input int n, input int c0, input int f0,
                           input int c1, input int f1);
        t_dir_row row;
        row.tx.data_byte      = b;
        row.tx.end_of_message = eom[0];
        row.typed             = typed[0];
        row.n                 = 2'(n);
        row.r0                = {c0[CODE_W-1:0], f0[0]};
        row.r1                = {c1[CODE_W-1:0], f1[0]};
        dir_rows.push_back(row);
    endtask

    task automatic note_mismatch(input lzwse_pkg::t_out want, input lzwse_pkg::t_out got,
                                 input bit orphan);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (orphan)
                $display("%0t: unexpected code %0d final %0b", $realtime,
                         got.code, got.final_code);
            else
                $display("%0t: code exp %0d got %0d, final exp %0b got %0b",
                         $realtime, want.code, got.code, want.final_code,
                         got.final_code);
        end
    endtask

    // result check against oldest expectation
    always @(posedge i_clk) begin : check_results
        lzwse_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (code_q.size() == 0) begin
                note_mismatch('0, o_data, 1'b1);
            end else begin
                want = code_q.pop_front();
                if (o_data.code !== want.code || o_data.final_code !== want.final_code)
                    note_mismatch(want, o_data, 1'b0);
            end
        end
    end

    // receiver: random ready bursts, long hold-off on request
    initial begin : receiver
        int n;
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                n = idle_on ? $urandom_range(1, 20) : 1;
                repeat (n) @(negedge i_clk);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_dir_row       row;
        logic [7:0]     pat [3];
        lzwse_pkg::t_in tx;
        int             i;
        int             k;

        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_data    = '0;
        free_code = lzwse_pkg::FIRST_CODE;
        cur_code  = '0;
        in_string = 1'b0;

        // one-byte messages at both byte extremes
        add_row(8'h00, 1, 1, 1, 8'h00, 1, 0, 0);
        add_row(8'hFF, 1, 1, 1, 8'hFF, 1, 0, 0);
        // first byte emits nothing, misses learn, a hit extends the string
        add_row(8'h41, 0, 1, 0, 0, 0, 0, 0);
        add_row(8'h42, 0, 1, 1, 8'h41, 0, 0, 0);
        add_row(8'h41, 0, 1, 1, 8'h42, 0, 0, 0);
        add_row(8'h42, 0, 1, 0, 0, 0, 0, 0);
        // miss on the last byte gives two codes
        add_row(8'h41, 1, 1, 2, lzwse_pkg::FIRST_CODE, 0, 8'h41, 1);
        add_row(8'h00, 0, 1, 0, 0, 0, 0, 0);
        add_row(8'hFF, 1, 1, 2, 8'h00, 0, 8'hFF, 1);
        // learned pair must be gone after the message ends
        add_row(8'h41, 0, 1, 0, 0, 0, 0, 0);
        add_row(8'h42, 1, 1, 2, 8'h41, 0, 8'h42, 1);
        add_row(8'h41, 0, 1, 0, 0, 0, 0, 0);
        add_row(8'h42, 1, 1, 2, 8'h41, 0, 8'h42, 1);
        // run of one byte builds ever longer strings
        for (k = 0; k < 6; k++) add_row(8'hAA, 0, 0, 0, 0, 0, 0, 0);
        add_row(8'hAA, 1, 0, 0, 0, 0, 0, 0);
        // extreme bytes inside keys
        add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(8'h00, 0, 0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1, 0, 0, 0, 0, 0, 0);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            drive_item(row.tx);
            lzw_predict(row.tx);
            if (row.typed) begin
                if (row.n >= 1) code_q.push_back(row.r0);
                if (row.n == 2) code_q.push_back(row.r1);
            end else begin
                for (k = 0; k < pred_n; k++) code_q.push_back(pred_res[k]);
            end
        end

        // random messages, one with the receiver held off
        while (rand_items < 400) begin
            if (rand_items >= 200 && !hold_req && rand_items < 260) begin
                hold_req = 1'b1;
                send_message(MSG_RANDOM, 60);
            end else begin
                random_message();
            end
        end

        // sender pause until everything has come out
        settle();

        // many tiny messages, enough to wrap the message epoch
        for (i = 0; i < 260; i++)
            send_message(t_msg_kind'($urandom_range(0, 3)), $urandom_range(1, 2));

        // long message: pattern, random fill, pattern again
        for (k = 0; k < 3; k++) pat[k] = 8'($urandom);
        for (i = 0; i < LONG_MSG_LEN; i++) begin
            if (i < LONG_RAND_LO || i >= LONG_RAND_HI)
                tx.data_byte = pat[i % 3];
            else
                tx.data_byte = 8'($urandom);
            tx.end_of_message = (i == LONG_MSG_LEN - 1);
            offer_byte(tx);
            rand_items++;
        end

        while (rand_items < 1000) random_message();

        // closing stretch without idling
        idle_on = 1'b0;
        while (rand_items < 1200) random_message();

        settle();
        if (mismatch_count == 0 && code_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
